// File: rtl/sync_length_frame_receiver_macros.svh
// Assertion macros for the frame receiver.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

`define SLFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slfr assertion failed");

`define SLFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slfr assertion failed");

`else

`define SLFR_ASSERT_IMP(label, ante, cons)

`define SLFR_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: rtl/slfr_pkg.sv
`default_nettype none

package slfr_pkg;

  localparam int MAX_PAYLOAD = 16;
  localparam int PAYLOAD_AW  = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 3;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_LEN = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_EMIT  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_CHECK = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LENGTH  = 2'd2
  } reg_idx_t;

  localparam logic [7:0]       SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]       SYNC_SECOND_RST = 8'h55;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 5'd16;

endpackage

`default_nettype wire

// File: rtl/slfr_ram.sv
`default_nettype none

module slfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/sync_length_frame_receiver.sv
// Frame receiver for a byte stream: sync one, sync two, type, length,
// payload, XOR check over type, length and payload.
// Input channel s_axis carries one received byte per transfer. Output
// channel m_axis carries result items; tlast marks the final item of a run.
// Configuration channel cfg writes sync_first (0), sync_second (1) and
// max_length (2); write it only while no frame is in progress.
// An oversize length byte, a bad check byte or the check byte of an empty
// frame loads its result into the output register when it is taken.
// A good frame of N payload bytes is read back from the payload RAM one
// entry per cycle while the output register is free: each result passes
// through the RAM read register and then the output register, and
// s_axis_tready stays low until the last one is loaded.
// Throughput: one byte per cycle while the output register is free.
// The single output register holds a result while m_axis_tready is low; the
// input is then stalled as well, and the emission run pauses.
// Reset (rst, synchronous) returns to waiting for sync one, restores the
// register defaults and drops any pending result. No clearing pass is needed.
`default_nettype none
`include "sync_length_frame_receiver_macros.svh"

module sync_length_frame_receiver
  import slfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] frame_type, [15:8] frame_length, [23:16] payload_byte,
  // [27:24] byte_position, [35:28] received_check, [43:36] computed_check,
  // [47:44] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser,   // [1:0] status, [2] payload_valid
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]            cfg_data
);

  phase_t phase, phase_next;

  logic [7:0]            sync_first;
  logic [7:0]            sync_second;
  logic [LEN_W-1:0]      max_length;
  logic [LEN_W-1:0]      limit;

  logic [7:0]            held_type;
  logic [LEN_W-1:0]      held_length;
  logic [7:0]            running_check;
  logic [7:0]            rx_check;
  logic [PAYLOAD_AW-1:0] wr_idx;
  logic [PAYLOAD_AW-1:0] rd_idx;

  logic [7:0]            ram_rdata;
  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [PAYLOAD_AW-1:0] ram_rd_addr;

  logic                  s_fire;
  logic                  slot_free;
  logic [7:0]            rx;
  logic [7:0]            len_check;
  logic                  too_long;
  logic                  check_ok;
  logic                  data_done;
  logic                  emit_last;

  logic                  out_load;
  status_t               out_status, out_status_next;
  logic [7:0]            out_length, out_length_next;
  logic [7:0]            out_payload, out_payload_next;
  logic [PAYLOAD_AW-1:0] out_pos, out_pos_next;
  logic                  out_pvalid, out_pvalid_next;
  logic [7:0]            out_rcheck, out_rcheck_next;
  logic [7:0]            out_ccheck, out_ccheck_next;
  logic [7:0]            out_type, out_type_next;
  logic                  out_last, out_last_next;

  assign rx        = s_axis_tdata;
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  assign limit     = (max_length > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : max_length;
  assign len_check = running_check ^ rx;
  assign too_long  = rx > {3'b000, limit};
  assign check_ok  = rx == running_check;
  assign data_done = ({1'b0, wr_idx} + LEN_W'(1)) >= held_length;
  assign emit_last = ({1'b0, rd_idx} + LEN_W'(1)) == held_length;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      max_length  <= MAX_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        REG_MAX_LENGTH:  max_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC2: if (s_fire) phase_next = (rx == sync_second) ? PH_TYPE : PH_SYNC1;
      PH_TYPE:  if (s_fire) phase_next = PH_LEN;
      PH_LEN: begin
        if (s_fire) begin
          if (too_long)        phase_next = PH_SYNC1;
          else if (rx == 8'd0) phase_next = PH_CHECK;
          else                 phase_next = PH_DATA;
        end
      end
      PH_DATA:  if (s_fire && data_done) phase_next = PH_CHECK;
      PH_CHECK: begin
        if (s_fire) begin
          phase_next = (check_ok && held_length != '0) ? PH_EMIT : PH_SYNC1;
        end
      end
      PH_EMIT:  if (slot_free && emit_last) phase_next = PH_SYNC1;
      default:  if (s_fire) phase_next = (rx == sync_first) ? PH_SYNC2 : PH_SYNC1;
    endcase
  end

  // phase outputs: handshake, RAM control, result load
  always_comb begin
    s_axis_tready    = slot_free;
    ram_wr_en        = 1'b0;
    ram_rd_en        = 1'b0;
    ram_rd_addr      = '0;
    out_load         = 1'b0;
    out_status_next  = ST_GOOD;
    out_type_next    = held_type;
    out_length_next  = {3'b000, held_length};
    out_payload_next = '0;
    out_pos_next     = '0;
    out_pvalid_next  = 1'b0;
    out_rcheck_next  = rx;
    out_ccheck_next  = running_check;
    out_last_next    = 1'b1;
    unique case (phase)
      PH_LEN: begin
        if (s_fire && too_long) begin
          out_load        = 1'b1;
          out_status_next = ST_TOO_LONG;
          out_length_next = rx;
          out_rcheck_next = '0;
          out_ccheck_next = len_check;
        end
      end
      PH_DATA: ram_wr_en = s_fire;
      PH_CHECK: begin
        if (s_fire) begin
          if (!check_ok) begin
            out_load        = 1'b1;
            out_status_next = ST_BAD_CHECK;
          end else if (held_length == '0) begin
            out_load = 1'b1;
          end else begin
            ram_rd_en = 1'b1;
          end
        end
      end
      PH_EMIT: begin
        s_axis_tready    = 1'b0;
        out_load         = slot_free;
        out_payload_next = ram_rdata;
        out_pos_next     = rd_idx;
        out_pvalid_next  = 1'b1;
        out_rcheck_next  = rx_check;
        out_last_next    = emit_last;
        ram_rd_en        = slot_free && !emit_last;
        ram_rd_addr      = rd_idx + PAYLOAD_AW'(1);
      end
      default: ;
    endcase
  end

  // frame datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      held_type     <= '0;
      held_length   <= '0;
      running_check <= '0;
      wr_idx        <= '0;
      rd_idx        <= '0;
    end else begin
      phase <= phase_next;
      if (s_fire) begin
        unique case (phase)
          PH_TYPE: begin
            held_type     <= rx;
            running_check <= rx;
          end
          PH_LEN: begin
            running_check <= len_check;
            wr_idx        <= '0;
            held_length   <= too_long ? '0 : rx[LEN_W-1:0];
          end
          PH_DATA: begin
            running_check <= len_check;
            wr_idx        <= wr_idx + PAYLOAD_AW'(1);
          end
          default: ;
        endcase
      end
      if (phase == PH_CHECK && s_fire) begin
        rd_idx <= '0;
      end else if (phase == PH_EMIT && slot_free) begin
        rd_idx <= rd_idx + PAYLOAD_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_CHECK && s_fire) begin
      rx_check <= rx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status  <= out_status_next;
      out_type    <= out_type_next;
      out_length  <= out_length_next;
      out_payload <= out_payload_next;
      out_pos     <= out_pos_next;
      out_pvalid  <= out_pvalid_next;
      out_rcheck  <= out_rcheck_next;
      out_ccheck  <= out_ccheck_next;
      out_last    <= out_last_next;
    end
  end

  assign m_axis_tdata = {4'b0000, out_ccheck, out_rcheck, out_pos, out_payload,
                         out_length, out_type};
  assign m_axis_tuser = {out_pvalid, out_status};
  assign m_axis_tlast = out_last;

  slfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_idx),
    .wr_data (rx),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata)
  );

  `SLFR_ASSERT_IMP(a_len_in_range, 1'b1, held_length <= MAX_PAYLOAD_LEN)
  `SLFR_ASSERT_IMP(a_wr_in_frame, phase == PH_DATA, {1'b0, wr_idx} < held_length)
  `SLFR_ASSERT_IMP(a_rd_in_frame, phase == PH_EMIT, {1'b0, rd_idx} < held_length)
  `SLFR_ASSERT_NXT(a_run_ends, phase == PH_EMIT && out_load && out_last_next,
                   phase == PH_SYNC1 && m_axis_tvalid && m_axis_tlast)
  `SLFR_ASSERT_IMP(a_no_input_in_run, phase == PH_EMIT, !s_axis_tready)

endmodule

`default_nettype wire

// File: bench/sync_length_frame_receiver_test.sv
`timescale 1ns / 100ps

module sync_length_frame_receiver_test;
  import slfr_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    status_t    status;
    logic [7:0] ftype;
    logic [7:0] flen;
    logic [7:0] pbyte;
    logic [3:0] pos;
    logic       pvalid;
    logic [7:0] rcheck;
    logic [7:0] ccheck;
    logic       last;
  } frame_result_t;

  class frame_board;
    logic [7:0]    sync_first;
    logic [7:0]    sync_second;
    logic [4:0]    max_length;
    phase_t        phase;
    logic [7:0]    payload_mem [MAX_PAYLOAD];
    int unsigned   wr_idx;
    logic [7:0]    held_type;
    logic [4:0]    held_len;
    logic [7:0]    running_check;
    frame_result_t awaited_results [$];
    int unsigned   mismatches;

    function new();
      sync_first    = SYNC_FIRST_RST;
      sync_second   = SYNC_SECOND_RST;
      max_length    = MAX_LENGTH_RST;
      phase         = PH_SYNC1;
      wr_idx        = 0;
      held_type     = 8'd0;
      held_len      = 5'd0;
      running_check = 8'd0;
      mismatches    = 0;
      foreach (payload_mem[i]) payload_mem[i] = 8'd0;
    endfunction

    function logic [4:0] length_limit();
      return (max_length > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : max_length;
    endfunction

    function void set_register(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_SYNC_FIRST:  sync_first = val;
        REG_SYNC_SECOND: sync_second = val;
        REG_MAX_LENGTH:  max_length = val[4:0];
        default: ;
      endcase
    endfunction

    function void add_result(status_t st, logic [7:0] flen, logic [7:0] pbyte,
                             logic [3:0] pos, logic pvalid, logic [7:0] rcheck,
                             logic last);
      frame_result_t r;
      r.status = st;
      r.ftype  = held_type;
      r.flen   = flen;
      r.pbyte  = pbyte;
      r.pos    = pos;
      r.pvalid = pvalid;
      r.rcheck = rcheck;
      r.ccheck = running_check;
      r.last   = last;
      awaited_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [4:0] limit;
      limit = length_limit();
      case (phase)
        PH_SYNC2: phase = (b == sync_second) ? PH_TYPE : PH_SYNC1;
        PH_TYPE: begin
          held_type     = b;
          running_check = b;
          phase         = PH_LEN;
        end
        PH_LEN: begin
          running_check = running_check ^ b;
          wr_idx        = 0;
          if (b > {3'b000, limit}) begin
            held_len = 5'd0;
            add_result(ST_TOO_LONG, b, 8'd0, 4'd0, 1'b0, 8'd0, 1'b1);
            phase = PH_SYNC1;
          end else begin
            held_len = b[4:0];
            phase    = (b == 8'd0) ? PH_CHECK : PH_DATA;
          end
        end
        PH_DATA: begin
          if (wr_idx < MAX_PAYLOAD) begin
            payload_mem[wr_idx] = b;
            wr_idx++;
          end
          running_check = running_check ^ b;
          if (wr_idx >= held_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          if (b == running_check) begin
            if (held_len == 5'd0) begin
              add_result(ST_GOOD, 8'd0, 8'd0, 4'd0, 1'b0, b, 1'b1);
            end else begin
              for (int i = 0; i < int'(held_len); i++)
                add_result(ST_GOOD, {3'b000, held_len}, payload_mem[i], 4'(i), 1'b1, b,
                           (i + 1 == int'(held_len)));
            end
          end else begin
            add_result(ST_BAD_CHECK, {3'b000, held_len}, 8'd0, 4'd0, 1'b0, b, 1'b1);
          end
          phase = PH_SYNC1;
        end
        default: phase = (b == sync_first) ? PH_SYNC2 : PH_SYNC1;
      endcase
    endfunction

    function string show(frame_result_t r);
      return $sformatf("st %0d type %02h len %02h byte %02h pos %0d pv %0b rchk %02h cchk %02h last %0b",
                       r.status, r.ftype, r.flen, r.pbyte, r.pos, r.pvalid, r.rcheck,
                       r.ccheck, r.last);
    endfunction

    function void match_result(frame_result_t got, logic [3:0] pad);
      frame_result_t want;
      logic bad;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("unexpected result: %s", show(got));
        return;
      end
      want = awaited_results.pop_front();
      bad = (got.status !== want.status) || (got.ftype !== want.ftype) ||
            (got.flen !== want.flen) || (got.pbyte !== want.pbyte) ||
            (got.pos !== want.pos) || (got.pvalid !== want.pvalid) ||
            (got.rcheck !== want.rcheck) || (got.ccheck !== want.ccheck) ||
            (got.last !== want.last) || (pad !== 4'd0);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result mismatch, expected: %s", show(want));
          $display("                 actual:   %s pad %h", show(got), pad);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [7:0]            cfg_data;

  frame_board    board;
  frame_result_t got_result;
  int unsigned   cycle_count = 0;
  int unsigned   rx_sent = 0;
  int            burst_left = 0;
  int            hold_left = 0;
  int            hold_mode = 0;

  logic [7:0] opening_seq [$] = '{
    8'hAA, 8'h00,
    8'hAA, 8'h55, 8'hFF, 8'h00, 8'hFF,
    8'hAA, 8'h55, 8'h00, 8'h11,
    8'hAA, 8'h55, 8'h7E, 8'h02, 8'hFF, 8'h00, 8'h80,
    8'hAA, 8'hAA, 8'h55,
    8'hAA, 8'h55, 8'h00, 8'hFF
  };

  sync_length_frame_receiver i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sync_length_frame_receiver verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_result.status = status_t'(m_axis_tuser[1:0]);
        got_result.pvalid = m_axis_tuser[2];
        got_result.ftype  = m_axis_tdata[7:0];
        got_result.flen   = m_axis_tdata[15:8];
        got_result.pbyte  = m_axis_tdata[23:16];
        got_result.pos    = m_axis_tdata[27:24];
        got_result.rcheck = m_axis_tdata[35:28];
        got_result.ccheck = m_axis_tdata[43:36];
        got_result.last   = m_axis_tlast;
        board.match_result(got_result, m_axis_tdata[47:44]);
      end
      if (hold_left == 0) begin
        hold_mode = $urandom_range(0, 3);
        hold_left = $urandom_range(10, 60);
      end else begin
        hold_left--;
      end
      case (hold_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (hold_left % 13 == 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 39) == 0 && board.awaited_results.size() != 0) begin
        s_axis_tvalid <= 1'b0;
        while (board.awaited_results.size() != 0) @(posedge clk);
      end else if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    board.take_byte(b);
    rx_sent++;
  endtask

  task automatic finish_frame();
    while (board.phase != PH_SYNC1) begin
      case (board.phase)
        PH_SYNC2: send_byte(~board.sync_second);
        PH_LEN:   send_byte(8'hFF);
        default:  send_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic settle();
    finish_frame();
    s_axis_tvalid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [4:0] ml);
    write_reg(REG_SYNC_FIRST, sf);
    write_reg(REG_SYNC_SECOND, ss);
    write_reg(REG_MAX_LENGTH, {3'b000, ml});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frames(input int unsigned count);
    int unsigned start;
    int          kind;
    int          len;
    int          lim;
    logic [7:0]  sum;
    logic [7:0]  ftype;
    logic [7:0]  p;
    start = rx_sent;
    while (rx_sent - start < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        finish_frame();
        lim = int'(board.length_limit());
        case ($urandom_range(0, 9))
          0, 1, 2: len = $urandom_range(0, (lim < 3) ? lim : 3);
          3, 4, 5: len = $urandom_range(0, lim);
          6, 7:    len = lim;
          8:       len = $urandom_range(lim + 1, 255);
          default: len = $urandom_range(0, 255);
        endcase
        ftype = 8'($urandom_range(0, 255));
        send_byte(board.sync_first);
        send_byte(board.sync_second);
        send_byte(ftype);
        send_byte(len[7:0]);
        sum = ftype ^ len[7:0];
        if (len <= lim) begin
          repeat (len) begin
            p   = 8'($urandom_range(0, 255));
            sum = sum ^ p;
            send_byte(p);
          end
          send_byte(($urandom_range(0, 5) == 0) ? sum ^ 8'($urandom_range(1, 255)) : sum);
        end
      end else if (kind < 18) begin
        send_byte(board.sync_first);
        if (kind == 16) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(board.sync_first);
          send_byte(board.sync_second);
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_SYNC_FIRST;
    cfg_data      <= 8'd0;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_seq[i]) send_byte(opening_seq[i]);
    run_frames(60);
    settle();

    program_regs(8'h00, 8'hFF, 5'd0);
    run_frames(40);
    settle();

    program_regs(8'hFF, 8'h00, 5'd1);
    run_frames(50);
    settle();

    program_regs(8'h3C, 8'h3C, 5'd16);
    run_frames(60);
    settle();

    program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 16)));
    run_frames(50);
    settle();

    program_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LENGTH_RST);
    run_frames(60);
    settle();

    if (board.mismatches == 0 && board.awaited_results.size() == 0) begin
      $display("sync_length_frame_receiver verification clean");
    end else begin
      $display("sync_length_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/slfr_pkg.sv
rtl/slfr_ram.sv
rtl/sync_length_frame_receiver.sv
bench/sync_length_frame_receiver_test.sv
